[rtl/core/mcdp_pkg.sv]
// shared types and constants for the composition data parser
`timescale 1ns / 1ps
package mcdp_pkg;

  localparam int unsigned OUT_DATA_W = 72;

  localparam logic [3:0] KIND_COMPANY  = 4'd0;
  localparam logic [3:0] KIND_FEATURES = 4'd4;
  localparam logic [3:0] KIND_ELEMENT  = 4'd5;
  localparam logic [3:0] KIND_SIG      = 4'd6;
  localparam logic [3:0] KIND_VENDOR   = 4'd7;
  localparam logic [3:0] KIND_SUMMARY  = 4'd8;

  localparam logic [1:0] BYTE_0 = 2'd0;
  localparam logic [1:0] BYTE_1 = 2'd1;
  localparam logic [1:0] BYTE_2 = 2'd2;
  localparam logic [1:0] BYTE_3 = 2'd3;

  typedef struct packed {
    logic        fld_valid;
    logic [3:0]  kind;
    logic [7:0]  index;
    logic [15:0] word;
    logic [15:0] model;
    logic [7:0]  sig_cnt;
    logic [7:0]  vnd_cnt;
    logic        sum_valid;
    logic [7:0]  total;
    logic        trunc;
  } rec_event_t;

endpackage

[rtl/core/mcdp_front.sv]
// byte parser that classifies descriptor bytes into record events
`timescale 1ns / 1ps
module mcdp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  output logic                ev_valid,
  output mcdp_pkg::rec_event_t ev
);
  import mcdp_pkg::*;

  typedef enum logic [5:0] {
    ST_HEADER    = 6'b000001,
    ST_LOCATION  = 6'b000010,
    ST_SIG_COUNT = 6'b000100,
    ST_VND_COUNT = 6'b001000,
    ST_SIG_MODEL = 6'b010000,
    ST_VND_MODEL = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  hdr_word, hdr_word_next;
  logic [1:0]  bif, bif_next;
  logic [7:0]  held_low, held_low_next;
  logic [15:0] held_vendor, held_vendor_next;
  logic [15:0] held_location, held_location_next;
  logic [7:0]  sig_rem, sig_rem_next;
  logic [7:0]  vnd_rem, vnd_rem_next;
  logic [7:0]  elem_cnt, elem_cnt_next;
  logic [7:0]  cur_index;
  logic [7:0]  sig_after, vnd_after;

  assign cur_index = (elem_cnt != 8'd0) ? elem_cnt - 8'd1 : 8'd0;

  always_comb begin
    phase_next         = phase;
    hdr_word_next      = hdr_word;
    bif_next           = bif;
    held_low_next      = held_low;
    held_vendor_next   = held_vendor;
    held_location_next = held_location;
    sig_rem_next       = sig_rem;
    vnd_rem_next       = vnd_rem;
    elem_cnt_next      = elem_cnt;
    sig_after          = sig_rem;
    vnd_after          = vnd_rem;
    ev                 = '0;

    case (phase)
      ST_HEADER: begin
        if (bif == BYTE_0) begin
          held_low_next = data_byte;
          bif_next      = BYTE_1;
        end else begin
          ev.fld_valid = 1'b1;
          ev.kind      = {1'b0, hdr_word};
          ev.word      = {data_byte, held_low};
          bif_next     = BYTE_0;
          if ({1'b0, hdr_word} == KIND_FEATURES) begin
            phase_next    = ST_LOCATION;
            hdr_word_next = 3'd0;
          end else begin
            hdr_word_next = hdr_word + 3'd1;
          end
        end
      end
      ST_LOCATION: begin
        if (bif == BYTE_0) begin
          held_low_next = data_byte;
          bif_next      = BYTE_1;
          if (elem_cnt != 8'hFF) elem_cnt_next = elem_cnt + 8'd1;
        end else begin
          held_location_next = {data_byte, held_low};
          bif_next           = BYTE_0;
          phase_next         = ST_SIG_COUNT;
        end
      end
      ST_SIG_COUNT: begin
        sig_rem_next = data_byte;
        bif_next     = BYTE_0;
        phase_next   = ST_VND_COUNT;
      end
      ST_VND_COUNT: begin
        vnd_rem_next = data_byte;
        vnd_after    = data_byte;
        ev.fld_valid = 1'b1;
        ev.kind      = KIND_ELEMENT;
        ev.index     = cur_index;
        ev.word      = held_location;
        ev.sig_cnt   = sig_rem;
        ev.vnd_cnt   = data_byte;
        bif_next     = BYTE_0;
        phase_next   = (sig_after != 8'd0) ? ST_SIG_MODEL :
                       (vnd_after != 8'd0) ? ST_VND_MODEL : ST_LOCATION;
      end
      ST_SIG_MODEL: begin
        if (bif == BYTE_0) begin
          held_low_next = data_byte;
          bif_next      = BYTE_1;
        end else begin
          ev.fld_valid = 1'b1;
          ev.kind      = KIND_SIG;
          ev.index     = cur_index;
          ev.word      = {data_byte, held_low};
          if (sig_rem != 8'd0) sig_after = sig_rem - 8'd1;
          sig_rem_next = sig_after;
          bif_next     = BYTE_0;
          phase_next   = (sig_after != 8'd0) ? ST_SIG_MODEL :
                         (vnd_after != 8'd0) ? ST_VND_MODEL : ST_LOCATION;
        end
      end
      ST_VND_MODEL: begin
        case (bif)
          BYTE_0: begin
            held_vendor_next = {8'd0, data_byte};
            bif_next         = BYTE_1;
          end
          BYTE_1: begin
            held_vendor_next = {data_byte, held_vendor[7:0]};
            bif_next         = BYTE_2;
          end
          BYTE_2: begin
            held_low_next = data_byte;
            bif_next      = BYTE_3;
          end
          default: begin
            ev.fld_valid = 1'b1;
            ev.kind      = KIND_VENDOR;
            ev.index     = cur_index;
            ev.word      = held_vendor;
            ev.model     = {data_byte, held_low};
            if (vnd_rem != 8'd0) vnd_after = vnd_rem - 8'd1;
            vnd_rem_next = vnd_after;
            bif_next     = BYTE_0;
            phase_next   = (sig_after != 8'd0) ? ST_SIG_MODEL :
                           (vnd_after != 8'd0) ? ST_VND_MODEL : ST_LOCATION;
          end
        endcase
      end
      default: begin
        // unreachable codes restart at an element location
        held_low_next = data_byte;
        bif_next      = BYTE_1;
        phase_next    = ST_LOCATION;
        if (elem_cnt != 8'hFF) elem_cnt_next = elem_cnt + 8'd1;
      end
    endcase

    if (final_byte) begin
      ev.sum_valid       = 1'b1;
      ev.total           = elem_cnt_next;
      ev.trunc           = !((phase_next == ST_LOCATION) && (bif_next == BYTE_0));
      phase_next         = ST_HEADER;
      hdr_word_next      = 3'd0;
      bif_next           = BYTE_0;
      held_low_next      = 8'd0;
      held_vendor_next   = 16'd0;
      held_location_next = 16'd0;
      sig_rem_next       = 8'd0;
      vnd_rem_next       = 8'd0;
      elem_cnt_next      = 8'd0;
    end
  end

  assign ev_valid = ev.fld_valid | ev.sum_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ST_HEADER;
      hdr_word      <= 3'd0;
      bif           <= BYTE_0;
      held_low      <= 8'd0;
      held_vendor   <= 16'd0;
      held_location <= 16'd0;
      sig_rem       <= 8'd0;
      vnd_rem       <= 8'd0;
      elem_cnt      <= 8'd0;
    end else if (accept) begin
      phase         <= phase_next;
      hdr_word      <= hdr_word_next;
      bif           <= bif_next;
      held_low      <= held_low_next;
      held_vendor   <= held_vendor_next;
      held_location <= held_location_next;
      sig_rem       <= sig_rem_next;
      vnd_rem       <= vnd_rem_next;
      elem_cnt      <= elem_cnt_next;
    end
  end

endmodule

[rtl/core/mcdp_queue.sv]
// short event queue between the parser and the output stage
`timescale 1ns / 1ps
module mcdp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mcdp_pkg::rec_event_t push_ev,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output mcdp_pkg::rec_event_t head_ev
);
  import mcdp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rec_event_t      mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_ev    = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/core/mcdp_back.sv]
// output stage that expands queued events into result words
`timescale 1ns / 1ps
module mcdp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  mcdp_pkg::rec_event_t          head_ev,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mcdp_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [3:0]                    m_tuser,
  output logic                          m_tlast
);
  import mcdp_pkg::*;

  logic fld_done;
  logic load;
  logic emit_fld;

  assign load     = !m_tvalid || m_tready;
  assign emit_fld = head_ev.fld_valid && !fld_done;
  assign pop      = load && head_valid && !(emit_fld && head_ev.sum_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      fld_done <= 1'b0;
    end else if (load) begin
      m_tvalid <= head_valid;
      if (head_valid) fld_done <= emit_fld && head_ev.sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (emit_fld) begin
        m_tuser <= head_ev.kind;
        m_tlast <= !head_ev.sum_valid;
        m_tdata <= {7'd0, 1'b0, 8'd0, head_ev.vnd_cnt, head_ev.sig_cnt,
                    head_ev.model, head_ev.word, head_ev.index};
      end else begin
        m_tuser <= KIND_SUMMARY;
        m_tlast <= 1'b1;
        m_tdata <= {7'd0, head_ev.trunc, head_ev.total, 8'd0, 8'd0,
                    16'd0, 16'd0, 8'd0};
      end
    end
  end

endmodule

[rtl/core/mesh_composition_data_parser_unit.sv]
// top level of the composition data parser
// one byte accepted per cycle while the event queue has room
// a field record is written into the event queue when its byte is taken, then loaded into the output register
// a final byte that also closes a field gives two words: the field word, then the summary word
// throughput is bounded by the single output register: one word per cycle while m_tready is high
// synchronous reset returns the parser to the company word and empties queue and output
`timescale 1ns / 1ps
module mesh_composition_data_parser_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // element_index, word_value, model_word, sig_model_count, vendor_model_count,
  // element_total, truncated, zero fill
  output logic [mcdp_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [3:0]                      m_tuser,   // record_kind
  output logic                            m_tlast
);
  import mcdp_pkg::*;

  logic       accept;
  logic       ev_valid;
  rec_event_t ev;
  logic       full;
  logic       pop;
  logic       head_valid;
  rec_event_t head_ev;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  mcdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .ev_valid   (ev_valid),
    .ev         (ev)
  );

  mcdp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && ev_valid),
    .push_ev    (ev),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_ev    (head_ev)
  );

  mcdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_ev    (head_ev),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[rtl/core/mcdp_checker.sv]
// port-level checks for the composition data parser
`timescale 1ns / 1ps
module mcdp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mcdp_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [3:0]                      m_tuser,
  input logic                            m_tlast
);
  import mcdp_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled word changed");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= KIND_SUMMARY)
    else $error("record kind out of range");

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_SUMMARY |-> m_tlast && m_tdata[55:0] == 56'd0)
    else $error("summary word malformed");

  a_field_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_SUMMARY |-> m_tdata[71:56] == 16'd0)
    else $error("field word carries summary bits");

endmodule

bind mesh_composition_data_parser_unit mcdp_checker u_mcdp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
